>>> sv/baot_pkg.sv
// Shared types, constants and helpers for the box array orthogonal transform.
package baot_pkg;

  // Default coordinate width of the box and pitch inputs.
  localparam int COORD_BITS_DEF = 32;

  // Result coordinates are 48-bit signed; counts are 16 bits.
  localparam int OUT_W   = 48;
  localparam int COUNT_W = 16;
  localparam int OFF_W   = 32;
  localparam int MAT_W   = 2;
  localparam int WIDE_W  = 64;

  localparam logic signed [OUT_W-1:0] MAX48 = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] MIN48 = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_XX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_XY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_YX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAT_YY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_Y  = 3'd5;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_BOX    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Clamp a wide signed value to the 48-bit signed range.
  function automatic logic signed [OUT_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > WIDE_W'(MAX48)) begin
      r = MAX48;
    end else if (v < WIDE_W'(MIN48)) begin
      r = MIN48;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/box_array_orthogonal_transform.sv
// Top level: orthogonal transform of a layout box with repetition array and running bound.
//
// Box array orthogonal transform. Each item is either a box to transform (kind 0), a request
// for the running bounding box (kind 1) or a clear of that bound (kind 2; kind 3 is a no-op
// that still returns an all-zero result). A box's corners go through the 2x3 transform held
// in the config registers (coefficients -1..1, code 2'b10 acts as -2), the edges are sorted
// low/high, the x/y repetition arrays are remapped (swapped under 90-degree rotation) and the
// extent including all repeats is returned and folded into the running bound. Every item
// yields exactly one result; all results saturate to 48 bits. Rate: one item per cycle
// sustained while the output is not stalled: an input register, then one pass of logic
// (transform adds, two 16x48 multiplies for the repeat extent, edge add, min/max) into
// the result register. The running bound is updated in that same pass, so a report that
// follows a box in the next cycle already sees it. Input stall only rises when both the
// input register and the result register are full and the output is stalled. Config writes
// are always taken (ready tied high) and must only happen while the block is idle. No
// clearing pass after reset: the bound resets to empty at once.
module box_array_orthogonal_transform
  import baot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [OFF_W-1:0]             cfg_data,
  // input item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   kind,
  input  logic signed [COORD_BITS-1:0] in_xl,
  input  logic signed [COORD_BITS-1:0] in_xr,
  input  logic signed [COORD_BITS-1:0] in_yb,
  input  logic signed [COORD_BITS-1:0] in_yt,
  input  logic signed [COORD_BITS-1:0] in_pitch_x,
  input  logic [COUNT_W-1:0]           in_count_x,
  input  logic signed [COORD_BITS-1:0] in_pitch_y,
  input  logic [COUNT_W-1:0]           in_count_y,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_W-1:0]      out_xl,
  output logic signed [OUT_W-1:0]      out_xr,
  output logic signed [OUT_W-1:0]      out_yb,
  output logic signed [OUT_W-1:0]      out_yt,
  output logic signed [OUT_W-1:0]      out_pitch_x,
  output logic [COUNT_W-1:0]           out_count_x,
  output logic signed [OUT_W-1:0]      out_pitch_y,
  output logic [COUNT_W-1:0]           out_count_y,
  output logic signed [OUT_W-1:0]      span_xl,
  output logic signed [OUT_W-1:0]      span_xr,
  output logic signed [OUT_W-1:0]      span_yb,
  output logic signed [OUT_W-1:0]      span_yt
);

  // coefficient times coordinate: magnitude up to 2^COORD_BITS
  localparam int MUL_W = COORD_BITS + 2;
  // two products plus a 32-bit offset
  localparam int SUM_W = ((COORD_BITS + 1 > OFF_W - 1) ? COORD_BITS + 1 : OFF_W - 1) + 2;
  localparam int PROD_W = COUNT_W + 1 + OUT_W;
  localparam int EDGE_W = OUT_W + 1;

  // coefficient code times value; 2'b10 is -2
  function automatic logic signed [MUL_W-1:0] mat_mul(input logic [MAT_W-1:0] m,
                                                       input logic signed [COORD_BITS-1:0] v);
    logic signed [MUL_W-1:0] ve;
    logic signed [MUL_W-1:0] r;
    ve = MUL_W'(v);
    unique case (m)
      2'b01:   r = ve;
      2'b11:   r = -ve;
      2'b10:   r = -(ve <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // config registers
  logic [MAT_W-1:0]        mat_xx, mat_xy, mat_yx, mat_yy;
  logic signed [OFF_W-1:0] off_x, off_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_xx <= 2'b01;
      mat_xy <= 2'b00;
      off_x  <= '0;
      mat_yx <= 2'b00;
      mat_yy <= 2'b01;
      off_y  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAT_XX: mat_xx <= cfg_data[MAT_W-1:0];
        REG_MAT_XY: mat_xy <= cfg_data[MAT_W-1:0];
        REG_OFF_X:  off_x  <= cfg_data;
        REG_MAT_YX: mat_yx <= cfg_data[MAT_W-1:0];
        REG_MAT_YY: mat_yy <= cfg_data[MAT_W-1:0];
        REG_OFF_Y:  off_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // handshake: input register (s_*) feeds the result register
  logic in_full, res_full;
  logic load_in, advance;

  assign advance   = in_full && (!res_full || !out_stall);
  assign in_stall  = in_full && res_full && out_stall;
  assign load_in   = in_valid && !in_stall;
  assign out_valid = res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (load_in) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        res_full <= 1'b1;
      end else if (!out_stall) begin
        res_full <= 1'b0;
      end
    end
  end

  kind_t                   s_kind;
  logic signed [COORD_BITS-1:0] s_xl, s_xr, s_yb, s_yt, s_px, s_py;
  logic [COUNT_W-1:0]      s_cx, s_cy;

  always_ff @(posedge clk) begin
    if (load_in) begin
      s_kind <= kind_t'(kind);
      s_xl   <= in_xl;
      s_xr   <= in_xr;
      s_yb   <= in_yb;
      s_yt   <= in_yt;
      s_px   <= in_pitch_x;
      s_cx   <= in_count_x;
      s_py   <= in_pitch_y;
      s_cy   <= in_count_y;
    end
  end

  // ---------------------------------------------------------------------------------------
  // running bound
  logic signed [OUT_W-1:0] bound_left, bound_right, bound_bottom, bound_top;

  // ---------------------------------------------------------------------------------------
  // transform pass
  logic signed [SUM_W-1:0] xl_sum, xr_sum, yb_sum, yt_sum;
  logic signed [SUM_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [OUT_W-1:0] box_xl, box_xr, box_yb, box_yt;
  logic signed [MUL_W-1:0] dx_pre, dy_pre;
  logic [COUNT_W-1:0]      nx, ny;
  logic signed [OUT_W-1:0] dx, dy;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [OUT_W-1:0] rep_x, rep_y;
  logic signed [EDGE_W-1:0] edge_xl, edge_xr, edge_yb, edge_yt;
  logic signed [OUT_W-1:0] ext_xl, ext_xr, ext_yb, ext_yt;

  always_comb begin
    xl_sum = SUM_W'(mat_mul(mat_xx, s_xl)) + SUM_W'(mat_mul(mat_xy, s_yb)) + SUM_W'(off_x);
    xr_sum = SUM_W'(mat_mul(mat_xx, s_xr)) + SUM_W'(mat_mul(mat_xy, s_yt)) + SUM_W'(off_x);
    yb_sum = SUM_W'(mat_mul(mat_yx, s_xl)) + SUM_W'(mat_mul(mat_yy, s_yb)) + SUM_W'(off_y);
    yt_sum = SUM_W'(mat_mul(mat_yx, s_xr)) + SUM_W'(mat_mul(mat_yy, s_yt)) + SUM_W'(off_y);

    // sort before clamping
    x_lo = (xl_sum > xr_sum) ? xr_sum : xl_sum;
    x_hi = (xl_sum > xr_sum) ? xl_sum : xr_sum;
    y_lo = (yb_sum > yt_sum) ? yt_sum : yb_sum;
    y_hi = (yb_sum > yt_sum) ? yb_sum : yt_sum;
    box_xl = sat48(WIDE_W'(x_lo));
    box_xr = sat48(WIDE_W'(x_hi));
    box_yb = sat48(WIDE_W'(y_lo));
    box_yt = sat48(WIDE_W'(y_hi));

    // array remap; a y array moved onto x overrides the x array
    nx = '0;
    ny = '0;
    dx_pre = '0;
    dy_pre = '0;
    if (s_cx != '0) begin
      if (mat_xx != 2'b00) begin
        nx = s_cx;
        dx_pre = mat_mul(mat_xx, s_px);
      end else begin
        ny = s_cx;
        dy_pre = mat_mul(mat_yx, s_px);
      end
    end
    if (s_cy != '0) begin
      if (mat_yy != 2'b00) begin
        ny = s_cy;
        dy_pre = mat_mul(mat_yy, s_py);
      end else begin
        nx = s_cy;
        dx_pre = mat_mul(mat_xy, s_py);
      end
    end
    dx = sat48(WIDE_W'(dx_pre));
    dy = sat48(WIDE_W'(dy_pre));

    // extent of all repeats; count is never negative
    prod_x = PROD_W'($signed({1'b0, nx})) * PROD_W'(dx);
    prod_y = PROD_W'($signed({1'b0, ny})) * PROD_W'(dy);
    rep_x  = sat48($signed(prod_x[WIDE_W-1:0]));
    rep_y  = sat48($signed(prod_y[WIDE_W-1:0]));

    edge_xl = EDGE_W'(box_xl) + EDGE_W'(rep_x);
    edge_xr = EDGE_W'(box_xr) + EDGE_W'(rep_x);
    edge_yb = EDGE_W'(box_yb) + EDGE_W'(rep_y);
    edge_yt = EDGE_W'(box_yt) + EDGE_W'(rep_y);

    ext_xl = box_xl;
    ext_xr = box_xr;
    ext_yb = box_yb;
    ext_yt = box_yt;
    if (nx != '0) begin
      if (rep_x[OUT_W-1]) begin
        ext_xl = sat48(WIDE_W'(edge_xl));
      end else begin
        ext_xr = sat48(WIDE_W'(edge_xr));
      end
    end
    if (ny != '0) begin
      if (rep_y[OUT_W-1]) begin
        ext_yb = sat48(WIDE_W'(edge_yb));
      end else begin
        ext_yt = sat48(WIDE_W'(edge_yt));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // result select: zero unless the kind fills a field
  logic signed [OUT_W-1:0] out_xl_next, out_xr_next, out_yb_next, out_yt_next;
  logic signed [OUT_W-1:0] out_pitch_x_next, out_pitch_y_next;
  logic [COUNT_W-1:0]      out_count_x_next, out_count_y_next;
  logic signed [OUT_W-1:0] span_xl_next, span_xr_next, span_yb_next, span_yt_next;

  always_comb begin
    out_xl_next      = '0;
    out_xr_next      = '0;
    out_yb_next      = '0;
    out_yt_next      = '0;
    out_pitch_x_next = '0;
    out_count_x_next = '0;
    out_pitch_y_next = '0;
    out_count_y_next = '0;
    span_xl_next     = '0;
    span_xr_next     = '0;
    span_yb_next     = '0;
    span_yt_next     = '0;
    // s_kind is only meaningful while the input register holds an item
    if (in_full) begin
      unique case (s_kind)
        KIND_BOX: begin
          out_xl_next      = box_xl;
          out_xr_next      = box_xr;
          out_yb_next      = box_yb;
          out_yt_next      = box_yt;
          out_pitch_x_next = dx;
          out_count_x_next = nx;
          out_pitch_y_next = dy;
          out_count_y_next = ny;
          span_xl_next     = ext_xl;
          span_xr_next     = ext_xr;
          span_yb_next     = ext_yb;
          span_yt_next     = ext_yt;
        end
        KIND_REPORT: begin
          span_xl_next = bound_left;
          span_xr_next = bound_right;
          span_yb_next = bound_bottom;
          span_yt_next = bound_top;
        end
        KIND_CLEAR, KIND_NONE: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // result register and bound update
  always_ff @(posedge clk) begin
    if (advance) begin
      out_xl      <= out_xl_next;
      out_xr      <= out_xr_next;
      out_yb      <= out_yb_next;
      out_yt      <= out_yt_next;
      out_pitch_x <= out_pitch_x_next;
      out_count_x <= out_count_x_next;
      out_pitch_y <= out_pitch_y_next;
      out_count_y <= out_count_y_next;
      span_xl     <= span_xl_next;
      span_xr     <= span_xr_next;
      span_yb     <= span_yb_next;
      span_yt     <= span_yt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_left   <= MAX48;
      bound_right  <= MIN48;
      bound_bottom <= MAX48;
      bound_top    <= MIN48;
    end else if (advance) begin
      unique case (s_kind)
        KIND_BOX: begin
          if (ext_xl < bound_left)   bound_left   <= ext_xl;
          if (ext_xr > bound_right)  bound_right  <= ext_xr;
          if (ext_yb < bound_bottom) bound_bottom <= ext_yb;
          if (ext_yt > bound_top)    bound_top    <= ext_yt;
        end
        KIND_CLEAR: begin
          bound_left   <= MAX48;
          bound_right  <= MIN48;
          bound_bottom <= MAX48;
          bound_top    <= MIN48;
        end
        KIND_REPORT, KIND_NONE: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a clear leaves the bound empty
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    advance && s_kind == KIND_CLEAR |=>
      bound_left == MAX48 && bound_right == MIN48 &&
      bound_bottom == MAX48 && bound_top == MIN48)
    else $error("bound not empty after clear");

  // the bound only grows unless cleared
  a_bound_grows: assert property (@(posedge clk) disable iff (rst)
    advance && s_kind != KIND_CLEAR |=>
      bound_left <= $past(bound_left) && bound_right >= $past(bound_right) &&
      bound_bottom <= $past(bound_bottom) && bound_top >= $past(bound_top))
    else $error("running bound shrank");

  // a box result is sorted and its extent covers it
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    advance && s_kind == KIND_BOX |=>
      out_xl <= out_xr && out_yb <= out_yt &&
      span_xl <= out_xl && span_xr >= out_xr &&
      span_yb <= out_yb && span_yt >= out_yt)
    else $error("box result out of order");

  // nothing is lost: a full input register with a free result stage moves on
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_full && !in_stall && !load_in |=> !in_full && res_full)
    else $error("item dropped between stages");
`endif

endmodule
